@@ hdl/binary_min_heap_queue_top_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// same-cycle implication, gated by reset
`define BMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmhq: same-cycle check failed");

// next-cycle implication, gated by reset
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmhq: next-cycle check failed");

`endif

@@ hdl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the min-priority queue cell row.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCNT_W   = 11;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        count_t;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic action;
        key_t key_in;
    } in_item_t;

    typedef struct packed {
        key_t              removed_key;
        key_t              current_min;
        logic [OCNT_W-1:0] entry_count;
        status_t           status;
    } out_item_t;

    // command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        key_t key;
    } cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic occ;
        logic lt;   // broadcast key sorts before this cell's entry, or the cell is empty
        key_t val;
    } link_t;

    localparam link_t LINK_NONE = '{occ: 1'b0, lt: 1'b0, val: '0};

endpackage

@@ hdl/bmhq_cell.sv @@
// ----------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted row: holds a key, shifts right on insert, left on
// remove.
// ----------------------------------------------------------------------------
module bmhq_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmhq_pkg::cmd_t        cmd,
    input  bmhq_pkg::link_t       left,
    input  bmhq_pkg::link_t       right,
    output bmhq_pkg::link_t       self
);

    logic            occ_reg;
    logic            occ_next;
    bmhq_pkg::key_t  val_reg;
    bmhq_pkg::key_t  val_next;
    logic            lt;

    assign lt = !occ_reg || (cmd.key < val_reg);

    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        if (cmd.ins && lt)
        begin
            if (left.lt)
            begin
                occ_next = left.occ;
                val_next = left.val;
            end
            else
            begin
                occ_next = 1'b1;
                val_next = cmd.key;
            end
        end
        else if (cmd.del)
        begin
            occ_next = right.occ;
            val_next = right.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign self = '{occ: occ_reg, lt: lt, val: val_reg};

endmodule

@@ hdl/bmhq_cell_row.sv @@
// ----------------------------------------------------------------------------
// bmhq_cell_row
// Chain of cells kept in ascending order, occupied cells packed at the head.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_top_macros.svh"

module bmhq_cell_row (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmhq_pkg::cmd_t        cmd,
    output bmhq_pkg::link_t       head0,
    output bmhq_pkg::link_t       head1
);

    bmhq_pkg::link_t links [bmhq_pkg::CAPACITY];

    for (genvar i = 0; i < bmhq_pkg::CAPACITY; i++)
    begin : g_cell
        bmhq_pkg::link_t left_l;
        bmhq_pkg::link_t right_l;

        if (i == 0)
        begin : g_first
            assign left_l = bmhq_pkg::LINK_NONE;
        end
        else
        begin : g_mid_l
            assign left_l = links[i-1];
        end

        if (i == bmhq_pkg::CAPACITY - 1)
        begin : g_last
            assign right_l = bmhq_pkg::LINK_NONE;
        end
        else
        begin : g_mid_r
            assign right_l = links[i+1];
        end

        bmhq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_l),
            .right (right_l),
            .self  (links[i])
        );

        if (i > 0)
        begin : g_chk
            // occupied cells form a prefix
            `BMHQ_ASSERT_NOW(a_prefix, clk, rst_n, links[i].occ, links[i-1].occ)
            // keys ascend along the row
            `BMHQ_ASSERT_NOW(a_order, clk, rst_n, links[i].occ, !(links[i].val < links[i-1].val))
            // insert position is a single boundary
            `BMHQ_ASSERT_NOW(a_lt_mono, clk, rst_n, links[i-1].lt, links[i].lt)
        end
    end

    assign head0 = links[0];
    assign head1 = links[1];

endmodule

@@ hdl/binary_min_heap_queue_top.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Min-priority queue of signed 32-bit keys with insert and remove-min.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : in_valid / in_stall / in_data (action, key_in). Action
//                insert adds key_in, action remove takes out the smallest key.
//   out channel: out_valid / out_stall / out_data, one transaction per input
//                transaction, in order.
//   A transaction accepted at an edge shows its result
//   on out_data right after that edge. Throughput is one transaction per
//   cycle while no result is held by out_stall; every cell of the sorted row
//   updates in the same cycle, so the cell row update sets the rate.
//   The output register decouples the sides: a new input is accepted while
//   the held result is being taken. While out_stall holds a result, in_stall
//   is raised and nothing moves.
//   Reset empties the queue at once (no clearing pass); out_valid drops.
//   Insert into a full queue reports status full and drops the key; remove
//   from an empty queue reports status empty.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_top_macros.svh"

module binary_min_heap_queue_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bmhq_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bmhq_pkg::out_item_t   out_data
);

    logic                  accept;
    logic                  is_del;
    logic                  full;
    logic                  empty;
    bmhq_pkg::cmd_t        cmd;
    bmhq_pkg::link_t       head0;
    bmhq_pkg::link_t       head1;
    bmhq_pkg::count_t      count_reg;
    bmhq_pkg::count_t      count_next;
    bmhq_pkg::count_t      count_new;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bmhq_pkg::out_item_t   out_data_reg;
    bmhq_pkg::out_item_t   out_data_next;
    bmhq_pkg::out_item_t   result;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_del   = (in_data.action == bmhq_pkg::ACT_REMOVE);
    assign full     = (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
    assign empty    = (count_reg == '0);

    assign cmd = '{ins: accept && !is_del && !full,
                   del: accept && is_del && !empty,
                   key: in_data.key_in};

    bmhq_cell_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head0 (head0),
        .head1 (head1)
    );

    always_comb
    begin
        count_new          = count_reg;
        result.removed_key = '0;
        result.current_min = head0.occ ? head0.val : '0;
        result.status      = bmhq_pkg::ST_OK;
        if (is_del)
        begin
            if (empty)
            begin
                result.status = bmhq_pkg::ST_EMPTY;
            end
            else
            begin
                result.removed_key = head0.val;
                count_new          = count_reg - 1'b1;
                result.current_min = head1.occ ? head1.val : '0;
            end
        end
        else
        begin
            if (full)
            begin
                result.status = bmhq_pkg::ST_FULL;
            end
            else
            begin
                count_new = count_reg + 1'b1;
                if (!head0.occ || (in_data.key_in < head0.val))
                begin
                    result.current_min = in_data.key_in;
                end
            end
        end
        result.entry_count = bmhq_pkg::OCNT_W'(count_new);
    end

    always_comb
    begin
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            count_next     = count_new;
            out_data_next  = result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // count and head cell agree on emptiness
    `BMHQ_ASSERT_NOW(a_cnt_head, clk, rst_n, 1'b1, (count_reg != '0) == head0.occ)
    // refused insert leaves the count alone and reports full
    `BMHQ_ASSERT_NEXT(a_full_hold, clk, rst_n, accept && !is_del && full, (count_reg == $past(count_reg)) && (out_data.status == bmhq_pkg::ST_FULL))
    // remove on empty reports empty and a zero key
    `BMHQ_ASSERT_NEXT(a_empty_rm, clk, rst_n, accept && is_del && empty, (out_data.status == bmhq_pkg::ST_EMPTY) && (out_data.removed_key == '0))

endmodule

@@ test/binary_min_heap_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb
// Self-checking bench for the min-priority queue: a heap tracker predicts
// every reply from the accepted requests, covering directed corners, random
// insert/remove mixes and a fill to capacity, under varied backpressure.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_tb;

    localparam int             CYCLE_LIMIT = 400000;
    localparam bmhq_pkg::key_t KEY_MIN     = 32'sh8000_0000;
    localparam bmhq_pkg::key_t KEY_MAX     = 32'sh7fff_ffff;

    // tracks queue contents as a binary min-heap and keeps the replies still owed
    class minheap_tracker;
        bmhq_pkg::key_t      heap_mem[bmhq_pkg::CAPACITY];
        int unsigned         fill;
        bmhq_pkg::out_item_t awaited_replies[$];
        int unsigned         errors;
        int unsigned         n_insert, n_remove, n_full, n_empty, peak_fill;

        function new();
            fill      = 0;
            errors    = 0;
            n_insert  = 0;
            n_remove  = 0;
            n_full    = 0;
            n_empty   = 0;
            peak_fill = 0;
        endfunction

        function void apply_request(bmhq_pkg::in_item_t req);
            bmhq_pkg::out_item_t rep;
            int unsigned         pos, par, kid;
            bmhq_pkg::key_t      tmp;
            rep        = '0;
            rep.status = bmhq_pkg::ST_OK;
            if (req.action == bmhq_pkg::ACT_INSERT)
            begin
                n_insert++;
                if (fill >= bmhq_pkg::CAPACITY)
                begin
                    rep.status = bmhq_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    heap_mem[fill] = req.key_in;
                    pos = fill;
                    fill++;
                    while (pos > 0)
                    begin
                        par = (pos - 1) / 2;
                        if (!(heap_mem[pos] < heap_mem[par])) break;
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[par];
                        heap_mem[par] = tmp;
                        pos = par;
                    end
                end
            end
            else
            begin
                n_remove++;
                if (fill == 0)
                begin
                    rep.status = bmhq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    rep.removed_key = heap_mem[0];
                    fill--;
                    heap_mem[0] = heap_mem[fill];
                    pos = 0;
                    forever
                    begin
                        kid = pos * 2 + 1;
                        if (kid >= fill) break;
                        // left child wins a tie
                        if (kid + 1 < fill && heap_mem[kid + 1] < heap_mem[kid]) kid++;
                        if (!(heap_mem[kid] < heap_mem[pos])) break;
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[kid];
                        heap_mem[kid] = tmp;
                        pos = kid;
                    end
                end
            end
            if (fill > peak_fill) peak_fill = fill;
            rep.current_min = (fill > 0) ? heap_mem[0] : '0;
            rep.entry_count = fill[bmhq_pkg::OCNT_W-1:0];
            awaited_replies = {awaited_replies, rep};
        endfunction

        function void check_reply(bmhq_pkg::out_item_t got);
            bmhq_pkg::out_item_t want;
            if (awaited_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply removed=%0d min=%0d count=%0d status=%0d",
                         $time, got.removed_key, got.current_min, got.entry_count,
                         got.status);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.removed_key !== want.removed_key)
            begin
                errors++;
                $display("%0t: removed_key expected %0d actual %0d",
                         $time, want.removed_key, got.removed_key);
            end
            if (got.current_min !== want.current_min)
            begin
                errors++;
                $display("%0t: current_min expected %0d actual %0d",
                         $time, want.current_min, got.current_min);
            end
            if (got.entry_count !== want.entry_count)
            begin
                errors++;
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bmhq_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bmhq_pkg::out_item_t out_data;

    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    hold_left      = 0;
    logic           hold_request   = 1'b0;
    int unsigned    cycle_count    = 0;
    minheap_tracker tracker        = new();

    binary_min_heap_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked for one
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    <= 400;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reply(out_data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with in_valid still high
    task automatic send_item(input bmhq_pkg::in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.apply_request(req);
        @(negedge clk);
    endtask

    task automatic send_op(input logic act, input bmhq_pkg::key_t key);
        bmhq_pkg::in_item_t req;
        req.action = act;
        req.key_in = key;
        send_item(req);
    endtask

    function automatic bmhq_pkg::key_t pick_key();
        case ($urandom_range(9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3:    return bmhq_pkg::key_t'($urandom_range(7)) - 4;   // crowd of duplicates
            4:       return KEY_MIN + bmhq_pkg::key_t'($urandom_range(3));
            default: return bmhq_pkg::key_t'($urandom());
        endcase
    endfunction

    // remove action still carries a random key, which must be ignored
    task automatic run_random(input int unsigned count, input int unsigned insert_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < insert_pct)
                send_op(bmhq_pkg::ACT_INSERT, pick_key());
            else
                send_op(bmhq_pkg::ACT_REMOVE, bmhq_pkg::key_t'($urandom()));
        end
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners
        send_op(bmhq_pkg::ACT_REMOVE, KEY_MAX);          // empty queue
        send_op(bmhq_pkg::ACT_INSERT, 32'sd0);
        send_op(bmhq_pkg::ACT_INSERT, KEY_MAX);
        send_op(bmhq_pkg::ACT_INSERT, KEY_MIN);
        send_op(bmhq_pkg::ACT_INSERT, -32'sd1);
        send_op(bmhq_pkg::ACT_INSERT, 32'sd1);
        send_op(bmhq_pkg::ACT_INSERT, 32'sd5);
        send_op(bmhq_pkg::ACT_INSERT, 32'sd5);           // equal to its sibling, stays put
        send_op(bmhq_pkg::ACT_INSERT, 32'sd5);
        send_op(bmhq_pkg::ACT_INSERT, KEY_MIN);          // duplicate minimum
        send_op(bmhq_pkg::ACT_INSERT, 32'sd3);
        for (int i = 0; i < 11; i++)
            send_op(bmhq_pkg::ACT_REMOVE, bmhq_pkg::key_t'($urandom()));
        send_op(bmhq_pkg::ACT_REMOVE, KEY_MIN);          // empty again

        // pressure: receiver holds off while the sender keeps offering
        set_idling(0, 0);
        hold_request = 1'b1;
        run_random(200, 95);
        set_idling(84, 0);
        run_random(200, 95);
        set_idling(0, 84);
        run_random(200, 95);
        set_idling(13, 13);
        run_random(200, 95);

        // top up to capacity, then knock on the full queue
        set_idling(0, 0);
        while (tracker.fill < bmhq_pkg::CAPACITY)
            send_op(bmhq_pkg::ACT_INSERT, pick_key());
        send_op(bmhq_pkg::ACT_INSERT, KEY_MIN);
        send_op(bmhq_pkg::ACT_INSERT, KEY_MAX);
        send_op(bmhq_pkg::ACT_REMOVE, 32'sd0);
        send_op(bmhq_pkg::ACT_INSERT, KEY_MIN);
        send_op(bmhq_pkg::ACT_INSERT, 32'sd0);
        in_valid <= 1'b0;

        while (tracker.awaited_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d inserts (%0d refused full) and %0d removes (%0d on empty),",
                 tracker.n_insert, tracker.n_full, tracker.n_remove, tracker.n_empty);
        $display("peak fill %0d of %0d, over %0d cycles with mixed backpressure.",
                 tracker.peak_fill, bmhq_pkg::CAPACITY, cycle_count);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_cell.sv
hdl/bmhq_cell_row.sv
hdl/binary_min_heap_queue_top.sv
test/binary_min_heap_queue_top_tb.sv
